FILE: design/smc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smc_pkg;

    // size limits of the line store and the row counter
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH      = 2'd0,
        REG_FRAME_HEIGHT     = 2'd1,
        REG_FOREGROUND_LEVEL = 2'd2
    } cfg_reg_t;

    localparam logic [10:0] FRAME_WIDTH_RST      = 11'd360;
    localparam logic [12:0] FRAME_HEIGHT_RST     = 13'd275;
    localparam logic [7:0]  FOREGROUND_LEVEL_RST = 8'd255;

    // one result word
    typedef struct packed {
        logic mark;
        logic center_on_border;
        logic frame_done;
    } smc_result_t;

    // shrink conditional mark patterns, ring NW,N,NE,E,SE,S,SW,W from msb down
    function automatic logic smc_ring_match(input logic [7:0] ring);
        logic hit;
        hit = 1'b0;
        case (ring) inside
            // bond 1 and bond 2
            8'h20, 8'h80, 8'h02, 8'h08,
            8'h10, 8'h40, 8'h01, 8'h04,
            // bond 3
            8'h30, 8'h60, 8'hC0, 8'h81, 8'h03, 8'h06, 8'h0C, 8'h18,
            // bond 4 and bond 5
            8'h38, 8'hE0, 8'h83, 8'h0E,
            8'hD0, 8'h58, 8'h61, 8'h34, 8'h70, 8'hC1, 8'h07, 8'h1C,
            // bond 6
            8'hD8, 8'h63, 8'hF0, 8'h78, 8'hE1, 8'hC3, 8'h87, 8'h0F, 8'h1E, 8'h3C,
            // bond 7 and bond 8
            8'hF8, 8'hE3, 8'h8F, 8'h3E,
            8'h7C, 8'hF1, 8'hC7, 8'h1F,
            // bond 9 and bond 10
            8'hFC, 8'h7E, 8'hF3, 8'hF9, 8'hE7, 8'hCF, 8'h9F, 8'h3F,
            8'hFE, 8'hFB, 8'hEF, 8'hBF: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

FILE: design/smc_line_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module smc_line_ram #(
    parameter int DATA_W = 2,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/shrink_conditional_mark_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Shrink conditional mark over a 3x3 window, one pixel word per cycle while s_ready
// is high. Pixels enter in raster order; a pixel is foreground when it equals
// foreground_level. The two previous rows live as two bits per column in one
// line RAM that is read when a pixel is taken and written back on the next
// cycle; the result of each pixel is formed in stage one and registered in the
// output buffer. A result word leaves for every pixel at row >= 1 and
// column >= 1 and describes the centre one row up and one column left; last
// row and column never appear. A four-word output buffer lets the input keep
// flowing while results wait. After reset the line RAM is swept to zero, one
// column per cycle, across all MAX_WIDTH columns; s_ready stays low until the
// sweep ends, while configuration writes are taken at any time.
module shrink_conditional_mark_unit #(
    parameter int MAX_WIDTH  = smc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = smc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_wr_en,
    input  wire logic [smc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [smc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // pixel input
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [7:0]                          s_pixel,
    // result output
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_mark,
    output logic                                     m_center_on_border,
    output logic                                     m_frame_done
);

    import smc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LW = (CW + 1 > 11) ? CW + 1 : 11;
    localparam int HL = (RW + 1 > 13) ? RW + 1 : 13;
    localparam int BUF_DEPTH = 4;
    localparam int BP = $clog2(BUF_DEPTH);

    // configuration registers
    logic [10:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [7:0]  foreground_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg      <= FRAME_WIDTH_RST;
            frame_height_reg     <= FRAME_HEIGHT_RST;
            foreground_level_reg <= FOREGROUND_LEVEL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:      frame_width_reg      <= cfg_wdata[10:0];
                REG_FRAME_HEIGHT:     frame_height_reg     <= cfg_wdata[12:0];
                REG_FOREGROUND_LEVEL: foreground_level_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // frame size in use, clamped to the supported range
    logic [LW-1:0] fw_ext, w_use;
    logic [HL-1:0] fh_ext, h_use;

    always_comb begin
        fw_ext = LW'(frame_width_reg);
        fh_ext = HL'(frame_height_reg);
        if (fw_ext < LW'(3)) begin
            w_use = LW'(3);
        end else if (fw_ext > LW'(MAX_WIDTH)) begin
            w_use = LW'(MAX_WIDTH);
        end else begin
            w_use = fw_ext;
        end
        if (fh_ext < HL'(3)) begin
            h_use = HL'(3);
        end else if (fh_ext > HL'(MAX_HEIGHT)) begin
            h_use = HL'(MAX_HEIGHT);
        end else begin
            h_use = fh_ext;
        end
    end

    // line RAM sweep after reset
    logic          clr_active_reg;
    logic [CW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + CW'(1);
            if (clr_addr_reg == CW'(MAX_WIDTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // position counters
    logic [CW-1:0] col_reg, col_next, c_cur;
    logic [RW-1:0] row_reg, row_next, r_cur;
    logic [LW-1:0] c_inc;
    logic [HL-1:0] r_inc;
    logic          accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        c_cur = (LW'(col_reg) >= w_use) ? '0 : col_reg;
        r_cur = (HL'(row_reg) >= h_use) ? '0 : row_reg;
        c_inc = LW'(c_cur) + LW'(1);
        r_inc = HL'(r_cur) + HL'(1);
        if (c_inc >= w_use) begin
            col_next = '0;
            row_next = (r_inc >= h_use) ? '0 : r_inc[RW-1:0];
        end else begin
            col_next = c_inc[CW-1:0];
            row_next = r_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage one: waits for the line RAM read of its column
    logic          s1_valid_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_cur_reg;
    logic          s1_emit_reg;
    logic          s1_border_reg;
    logic          s1_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg    <= c_cur;
            s1_cur_reg    <= (s_pixel == foreground_level_reg);
            s1_emit_reg   <= (r_cur != '0) && (c_cur != '0);
            s1_border_reg <= (r_cur == RW'(1)) || (c_cur == CW'(1));
            s1_done_reg   <= (LW'(c_cur) == w_use - LW'(1)) &&
                             (HL'(r_cur) == h_use - HL'(1));
        end
    end

    // line RAM: bit 0 row two above, bit 1 row above
    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    logic [1:0]    ram_wdata;
    logic [1:0]    ram_rdata;

    always_comb begin
        if (clr_active_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = 2'b00;
        end else begin
            ram_we    = s1_valid_reg;
            ram_waddr = s1_col_reg;
            ram_wdata = {s1_cur_reg, ram_rdata[1]};
        end
    end

    smc_line_ram #(
        .DATA_W (2),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (c_cur),
        .rd_data (ram_rdata)
    );

    // window shift and pattern match
    logic [8:0]  win_reg, win_next;
    logic [7:0]  ring;
    smc_result_t s1_result;

    always_comb begin
        win_next = {s1_cur_reg, ram_rdata[1], ram_rdata[0], win_reg[8:3]};
        ring = {win_next[0], win_next[3], win_next[6], win_next[7],
                win_next[8], win_next[5], win_next[2], win_next[1]};
        s1_result.mark = !s1_border_reg && win_next[4] && smc_ring_match(ring);
        s1_result.center_on_border = s1_border_reg;
        s1_result.frame_done       = s1_done_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (s1_valid_reg) begin
            win_reg <= win_next;
        end
    end

    // output word buffer
    smc_result_t   buf_mem [BUF_DEPTH];
    logic [BP-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [BP:0]   buf_cnt_reg;
    logic          push, pop;

    assign push = s1_valid_reg && s1_emit_reg;
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_mem[wr_ptr_reg] <= s1_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            buf_cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + BP'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + BP'(1);
            end
            buf_cnt_reg <= buf_cnt_reg + (BP+1)'(push) - (BP+1)'(pop);
        end
    end

    assign m_valid            = (buf_cnt_reg != '0);
    assign m_mark             = buf_mem[rd_ptr_reg].mark;
    assign m_center_on_border = buf_mem[rd_ptr_reg].center_on_border;
    assign m_frame_done       = buf_mem[rd_ptr_reg].frame_done;

    // take a pixel only after the sweep and when the buffer has room for its result
    assign s_ready = !clr_active_reg &&
                     ((buf_cnt_reg + (BP+1)'(s1_valid_reg)) < (BP+1)'(BUF_DEPTH));

    // checks
    a_buf_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> buf_cnt_reg < (BP+1)'(BUF_DEPTH))
        else $error("result buffer overflow");

    a_no_pixel_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s1_valid_reg)
        else $error("pixel in flight during line RAM sweep");

    a_sweep_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clr_active_reg |=> !clr_active_reg)
        else $error("line RAM sweep restarted");

    a_done_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> !m_center_on_border)
        else $error("frame end flagged on a border centre");

    a_border_no_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_center_on_border |-> !m_mark)
        else $error("border centre marked");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

import smc_pkg::*;

localparam int LINE_DEPTH  = DEF_MAX_WIDTH;
localparam int ROW_LIMIT   = DEF_MAX_HEIGHT;
localparam int RING_COUNT  = 58;
localparam int CYCLE_LIMIT = 200000;
localparam int SETTLE_CYCLES = 16;

// rings (NW,N,NE,E,SE,S,SW,W from msb down) that mark a set centre, bonds 1 to 10
localparam logic [7:0] MARK_RINGS [RING_COUNT] = '{
    8'h20, 8'h80, 8'h02, 8'h08,
    8'h10, 8'h40, 8'h01, 8'h04,
    8'h30, 8'h60, 8'hC0, 8'h81, 8'h03, 8'h06, 8'h0C, 8'h18,
    8'h38, 8'hE0, 8'h83, 8'h0E,
    8'hD0, 8'h58, 8'h61, 8'h34, 8'h70, 8'hC1, 8'h07, 8'h1C,
    8'hD8, 8'h63, 8'hF0, 8'h78, 8'hE1, 8'hC3, 8'h87, 8'h0F, 8'h1E, 8'h3C,
    8'hF8, 8'hE3, 8'h8F, 8'h3E,
    8'h7C, 8'hF1, 8'hC7, 8'h1F,
    8'hFC, 8'h7E, 8'hF3, 8'hF9, 8'hE7, 8'hCF, 8'h9F, 8'h3F,
    8'hFE, 8'hFB, 8'hEF, 8'hBF
};

// mirror of the window logic plus the queue of result words still owed
class mark_tracker;
    logic [10:0]  width_reg;
    logic [12:0]  height_reg;
    logic [7:0]   level_reg;
    logic         line_prev [LINE_DEPTH];
    logic         line_prev2 [LINE_DEPTH];
    logic [8:0]   window;
    int unsigned  col_at;
    int unsigned  row_at;
    smc_result_t  owed_words [$];
    int           errors;

    function new();
        width_reg  = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        level_reg  = FOREGROUND_LEVEL_RST;
        foreach (line_prev[i]) begin
            line_prev[i]  = 1'b0;
            line_prev2[i] = 1'b0;
        end
        window = '0;
        col_at = 0;
        row_at = 0;
        errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_FRAME_WIDTH:      width_reg  = value[10:0];
            REG_FRAME_HEIGHT:     height_reg = value[12:0];
            REG_FOREGROUND_LEVEL: level_reg  = value[7:0];
            default: ;
        endcase
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function bit is_mark_ring(logic [7:0] ring);
        foreach (MARK_RINGS[i]) begin
            if (MARK_RINGS[i] == ring) return 1'b1;
        end
        return 1'b0;
    endfunction

    function int pending();
        return owed_words.size();
    endfunction

    // advance the window by one accepted pixel and queue the word it causes
    function void note_pixel(logic [7:0] px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        logic         cur;
        logic [7:0]   ring;
        smc_result_t  word;
        w = clamp_dim(width_reg, LINE_DEPTH);
        h = clamp_dim(height_reg, ROW_LIMIT);
        // counters left over from a larger size restart at zero
        if (col_at >= w) col_at = 0;
        if (row_at >= h) row_at = 0;
        c = col_at;
        r = row_at;
        cur = (px == level_reg);
        window = {cur, line_prev[c], line_prev2[c], window[8:3]};
        line_prev2[c] = line_prev[c];
        line_prev[c]  = cur;
        if (r >= 1 && c >= 1) begin
            ring = {window[0], window[3], window[6], window[7],
                    window[8], window[5], window[2], window[1]};
            word.center_on_border = (r == 1) || (c == 1);
            word.mark       = !word.center_on_border && window[4] && is_mark_ring(ring);
            word.frame_done = (r == h - 1) && (c == w - 1);
            owed_words.push_back(word);
        end
        col_at = c + 1;
        if (col_at >= w) begin
            col_at = 0;
            row_at = r + 1;
            if (row_at >= h) row_at = 0;
        end
    endfunction

    // compare one result word with the oldest one owed
    function void check_word(logic mark, logic on_border, logic done);
        smc_result_t want;
        if (owed_words.size() == 0) begin
            $error("result word with none expected: mark %0b border %0b done %0b",
                   mark, on_border, done);
            errors++;
            return;
        end
        want = owed_words.pop_front();
        if (mark !== want.mark) begin
            $error("mark: expected %0b, got %0b", want.mark, mark);
            errors++;
        end
        if (on_border !== want.center_on_border) begin
            $error("center_on_border: expected %0b, got %0b",
                   want.center_on_border, on_border);
            errors++;
        end
        if (done !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b", want.frame_done, done);
            errors++;
        end
    endfunction
endclass

module testbench;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    cfg_reg_t                cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_pixel   = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    logic                    m_mark;
    logic                    m_center_on_border;
    logic                    m_frame_done;

    mark_tracker  book = new();
    int           src_idle_pct   = 0;
    int           sink_stall_pct = 0;
    logic [7:0]   level_now      = FOREGROUND_LEVEL_RST;
    int           cycle_count    = 0;

    // two 3x3 frames: lone north neighbour (bond 2), all but west (bond 10)
    logic [7:0] directed_pixels [18] = '{
        8'd0,   8'd255, 8'd1,
        8'd254, 8'd255, 8'd128,
        8'd127, 8'd0,   8'd0,
        8'd255, 8'd255, 8'd255,
        8'd0,   8'd255, 8'd255,
        8'd255, 8'd255, 8'd255
    };

    shrink_conditional_mark_unit DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_pixel            (s_pixel),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_mark             (m_mark),
        .m_center_on_border (m_center_on_border),
        .m_frame_done       (m_frame_done)
    );

    always #4 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // result word monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            book.check_word(m_mark, m_center_on_border, m_frame_done);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[shrink_conditional_mark_unit] ERROR");
            $finish;
        end
    end

    // offer one pixel word after a random gap and wait for it to be taken
    task automatic push_pixel(input logic [7:0] px);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        book.note_pixel(px);
    endtask

    // drop valid, then wait for every owed word
    task automatic hold_until_empty();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (book.pending() != 0) @(posedge aclk);
    endtask

    // wait for all owed words, then for pixels that cause none to clear the pipe
    task automatic drain();
        hold_until_empty();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        book.set_reg(idx, value);
    endtask

    // unused upper data bits carry junk, the block must ignore them
    task automatic load_regs(input int unsigned w, input int unsigned h,
                             input int unsigned lvl);
        drain();
        write_reg(REG_FRAME_WIDTH, {2'($urandom), 11'(w)});
        write_reg(REG_FRAME_HEIGHT, 13'(h));
        write_reg(REG_FOREGROUND_LEVEL, {5'($urandom), 8'(lvl)});
        cfg_wr_en <= 1'b0;
        level_now = 8'(lvl);
    endtask

    // foreground with the given odds, else any other value, often one bit off
    function automatic logic [7:0] pick_pixel(input int fg_pct);
        logic [7:0] v;
        if ($urandom_range(0, 99) < fg_pct) return level_now;
        if ($urandom_range(0, 3) == 0) begin
            v = level_now ^ (8'd1 << $urandom_range(0, 7));
        end else begin
            v = 8'($urandom);
            if (v == level_now) v = ~v;
        end
        return v;
    endfunction

    task automatic run_phase(input int unsigned w, input int unsigned h,
                             input int unsigned lvl, input int fg_pct,
                             input int src_pct, input int sink_pct,
                             input int count, input bit hold_mid);
        load_regs(w, h, lvl);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < count; i++) begin
            if (hold_mid && i == count / 2) hold_until_empty();
            push_pixel(pick_pixel(fg_pct));
        end
    endtask

    // stimulus
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames at the smallest size
        load_regs(3, 3, 255);
        foreach (directed_pixels[i]) push_pixel(directed_pixels[i]);

        // random frames, sizes and levels, with every idling mix
        run_phase(3, 3, 255, 50, 0, 0, 90, 1'b0);
        run_phase(5, 4, 0, 60, 84, 0, 90, 1'b1);
        run_phase($urandom_range(3, 12), $urandom_range(3, 8), $urandom_range(0, 255),
                  45, 0, 84, 90, 1'b0);
        run_phase(1024, 3, 255, 50, 0, 0, 1030, 1'b0);
        // oversize values clamp to the line store and row limits
        run_phase(2047, 8191, 128, 50, 25, 25, 40, 1'b0);
        // undersize values clamp to three
        run_phase(0, 0, 1, 80, 25, 25, 90, 1'b0);
        run_phase(2, 1, $urandom_range(0, 255), 25, 0, 84, 100, 1'b0);
        run_phase(7, 4096, $urandom_range(0, 255), 55, 84, 0, 90, 1'b0);
        run_phase($urandom_range(3, 16), $urandom_range(3, 10), $urandom_range(0, 255),
                  70, 0, 0, 90, 1'b0);
        run_phase($urandom_range(3, 9), $urandom_range(3, 6), $urandom_range(0, 255),
                  35, 25, 25, 90, 1'b0);

        // let the last words out, then look for strays
        drain();
        if (book.errors == 0) begin
            $display("[shrink_conditional_mark_unit] OK");
        end else begin
            $display("[shrink_conditional_mark_unit] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/smc_pkg.sv
design/smc_line_ram.sv
design/shrink_conditional_mark_unit.sv
sim/testbench.sv
